@@ hdl/tta_pkg.sv @@
// Package for the thermistor temperature averager: FSM states, register
// indexes, unit status struct, fixed-point constants and small helpers.
// No dependencies.
package tta_pkg;

    // Field and port widths
    localparam int ADC_W      = 12;
    localparam int TEMP_W     = 16;
    localparam int SUM_W      = 24;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int DATA_W     = 64;

    // Default parameter values
    localparam int ADC_BITS_DEF   = 12;
    localparam int MAX_WINDOW_DEF = 64;

    // Register reset values
    localparam logic [19:0]        RS_RESET    = 20'd10000;
    localparam logic [19:0]        RN_RESET    = 20'd10000;
    localparam logic [13:0]        BETA_RESET  = 14'd3950;
    localparam logic signed [14:0] NT_RESET    = 15'sd2500;
    localparam logic [22:0]        VREF_RESET  = 23'd3300000;
    localparam logic [11:0]        FS_RESET    = 12'd4095;
    localparam logic [6:0]         WIN_RESET   = 7'd10;

    // Fixed-point constants
    localparam logic signed [63:0] HALF_SCALE = 64'sd500000000;
    localparam logic signed [63:0] POLY_SCALE = 64'sd1000000000;
    localparam logic [63:0]        LN2_Q24    = 64'd11629080;
    localparam logic [63:0]        LN_ROUND   = 64'd536870912;
    localparam logic signed [63:0] KELVIN     = 64'sd27315;
    localparam logic signed [25:0] SUM_MAX    = 26'sd8388607;
    localparam logic signed [25:0] SUM_MIN    = -26'sd8388608;
    localparam logic signed [25:0] T16_MAX    = 26'sd32767;
    localparam logic signed [25:0] T16_MIN    = -26'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERIES, REG_NOMINAL_R, REG_BETA, REG_NOMINAL_T,
        REG_VREF, REG_FULL_SCALE, REG_WINDOW
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_POLY, ST_VDIV, ST_RMUL_A, ST_RMUL_B, ST_NORM,
        ST_SQR, ST_LN, ST_DEN, ST_NUM, ST_TDIV, ST_ASTART, ST_AWAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    // Polynomial coefficients in 1e-9 uV, highest order first
    function automatic logic signed [63:0] poly_coef(input logic [2:0] idx);
        logic signed [63:0] c;
        case (idx)
            3'd0:    c = -64'sd16;
            3'd1:    c = 64'sd118171;
            3'd2:    c = -64'sd301211691;
            3'd3:    c = 64'sd1109019271794;
            3'd4:    c = 64'sd34143524634089;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

    // Saturate to 16 bit signed
    function automatic logic signed [15:0] clamp_t16(input logic signed [25:0] x);
        logic signed [15:0] y;
        if (x > T16_MAX) begin
            y = 16'sh7fff;
        end else if (x < T16_MIN) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage

@@ hdl/thermistor_temperature_averager.sv @@
// Top level of the thermistor temperature averager: sequencer, state and
// configuration registers. Depends on tta_pkg, tta_serial_mul, tta_serial_div.
//
// One ADC beat in, one result beat out. Each reading is linearized by a
// fourth-order polynomial, turned into a divider resistance ratio, taken
// through log2 and the beta equation, and folded into a running average in
// 0.01 degC. All multiplies and divides run through one shift-add multiplier
// (one bit a cycle) and one restoring divider. Most of a valid reading's time
// goes to the 60 serial squarings of the two log2 evaluations. A rejected
// reading skips the remaining arithmetic at the check that fails: the raw
// reading range, the sign of the polynomial, the voltage checks, or the
// denominator check after the logs. The input is stalled while a reading is
// in work; the result register lets the next reading enter while a result
// waits to be taken.
module thermistor_temperature_averager #(
    parameter int ADC_BITS   = tta_pkg::ADC_BITS_DEF,
    parameter int MAX_WINDOW = tta_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tta_pkg::ADC_W-1:0]            i_adc_reading,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tta_pkg::TEMP_W-1:0]    o_average_temperature,
    output logic                                 o_reading_invalid,
    input  logic                                 i_cfg_we,
    input  logic [tta_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tta_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tta_pkg::*;

    localparam int RB = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam int HW = $clog2(MAX_WINDOW + 1);
    localparam int CW = ((HW > WIN_W) ? HW : WIN_W) + 1;

    // Configuration registers
    logic [19:0]        r_rs;
    logic [19:0]        r_rn;
    logic [13:0]        r_beta;
    logic signed [14:0] r_nt;
    logic [22:0]        r_vref;
    logic [11:0]        r_fs;
    logic [6:0]         r_win;

    // Sequencer registers
    t_state             r_state, n_state;
    logic               r_invalid, n_invalid;
    logic               r_phase, n_phase;
    logic [ADC_W-1:0]   r_rd, n_rd;
    logic [1:0]         r_pi, n_pi;
    logic [22:0]        r_v, n_v;
    logic [63:0]        r_x, n_x;
    logic [5:0]         r_s, n_s;
    logic [5:0]         r_k, n_k;
    logic [29:0]        r_frac, n_frac;
    logic [4:0]         r_j, n_j;
    logic               r_sel, n_sel;
    logic               r_dneg, n_dneg;
    logic [63:0]        r_la, n_la;
    logic [63:0]        r_den, n_den;
    logic signed [15:0] r_temp, n_temp;
    logic signed [23:0] r_sum, n_sum;
    logic [HW-1:0]      r_held, n_held;
    logic signed [15:0] r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_avg, n_out_avg;
    logic               r_out_inv, n_out_inv;

    // Shared arithmetic units
    logic               mul_start, div_start;
    logic [63:0]        mul_a, mul_b, mul_prod;
    logic [63:0]        div_n, div_d, div_q;
    t_unit_status       mul_stat, div_stat;

    tta_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_a),
        .i_mplier (mul_b),
        .o_prod   (mul_prod),
        .o_status (mul_stat)
    );

    tta_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_quotient (div_q),
        .o_status   (div_stat)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs   <= RS_RESET;
            r_rn   <= RN_RESET;
            r_beta <= BETA_RESET;
            r_nt   <= NT_RESET;
            r_vref <= VREF_RESET;
            r_fs   <= FS_RESET;
            r_win  <= WIN_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SERIES:     r_rs   <= i_cfg_data[19:0];
                REG_NOMINAL_R:  r_rn   <= i_cfg_data[19:0];
                REG_BETA:       r_beta <= i_cfg_data[13:0];
                REG_NOMINAL_T:  r_nt   <= $signed(i_cfg_data[14:0]);
                REG_VREF:       r_vref <= i_cfg_data[22:0];
                REG_FULL_SCALE: r_fs   <= i_cfg_data[11:0];
                REG_WINDOW:     r_win  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Derived operands
    logic signed [63:0] t0;
    logic [63:0]        b64, b100, vdiff, rs64, rn64, r64;
    logic [CW-1:0]      win_c, w_eff, held_c;
    logic               sum_neg;
    logic [23:0]        sum_mag;
    logic [63:0]        avg_n, avg_d;
    logic signed [24:0] avg_s;

    always_comb begin
        t0    = $signed({{49{r_nt[14]}}, r_nt}) + KELVIN;
        b64   = {50'd0, r_beta};
        b100  = (b64 << 6) + (b64 << 5) + (b64 << 2);
        vdiff = {41'd0, r_vref} - {41'd0, r_v};
        rs64  = {44'd0, r_rs};
        rn64  = {44'd0, r_rn};
        r64   = {52'd0, r_rd};
        // Effective window: zero acts as one, capped at the maximum
        win_c = CW'(r_win);
        if (r_win == '0) begin
            w_eff = CW'(1);
        end else if (win_c > CW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = win_c;
        end
        held_c = CW'(r_held);
        // Rounded average of sum over count, halves away from zero
        sum_neg = r_sum[23];
        sum_mag = sum_neg ? 24'(-r_sum) : 24'(r_sum);
        avg_n   = {40'd0, sum_mag} + 64'(r_held >> 1);
        avg_d   = 64'(r_held);
        if (r_held == '0) begin
            avg_s = '0;
        end else if (sum_neg) begin
            avg_s = -$signed(div_q[24:0]);
        end else begin
            avg_s = $signed(div_q[24:0]);
        end
    end

    // Sequencer: next state and unit requests
    logic signed [63:0] acc_n, den_s, tc, d_s;
    logic [31:0]        mm;
    logic [30:0]        m_nx;
    logic [29:0]        frac_nx;
    logic [63:0]        logv, lm, mag;
    logic signed [25:0] s26, avg26;

    always_comb begin
        n_state     = r_state;
        n_invalid   = r_invalid;
        n_phase     = r_phase;
        n_rd        = r_rd;
        n_pi        = r_pi;
        n_v         = r_v;
        n_x         = r_x;
        n_s         = r_s;
        n_k         = r_k;
        n_frac      = r_frac;
        n_j         = r_j;
        n_sel       = r_sel;
        n_dneg      = r_dneg;
        n_la        = r_la;
        n_den       = r_den;
        n_temp      = r_temp;
        n_sum       = r_sum;
        n_held      = r_held;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_inv   = r_out_inv;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_n       = '0;
        div_d       = '0;
        acc_n       = $signed(mul_prod) + poly_coef({1'b0, r_pi} + 3'd1);
        mm          = mul_prod[61:30];
        m_nx        = mm[31] ? mm[31:1] : mm[30:0];
        frac_nx     = {r_frac[28:0], mm[31]};
        logv        = {28'd0, r_k, frac_nx};
        d_s         = $signed(r_la) - $signed(logv);
        mag         = d_s[63] ? 64'(-d_s) : 64'(d_s);
        lm          = (mul_prod + LN_ROUND) >> 30;
        den_s       = $signed(b100 << 24) + $signed(mul_prod);
        tc          = $signed(div_q) - KELVIN;
        avg26       = 26'(avg_s);
        s26         = 26'(r_sum) + 26'(r_temp);
        if (held_c >= w_eff) begin
            s26 = s26 - avg26;
        end

        // Result register drains independently
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_rd      = ADC_W'(i_adc_reading[RB-1:0]);
                    n_invalid = 1'b0;
                    n_phase   = 1'b0;
                    n_state   = ST_CHECK;
                end
            end
            // Reading range check, then first Horner step
            ST_CHECK: begin
                if (r_rd == '0 || r_rd > r_fs) begin
                    n_invalid = 1'b1;
                    n_state   = ST_ASTART;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = poly_coef(3'd0);
                    mul_b     = r64;
                    n_pi      = 2'd0;
                    n_state   = ST_POLY;
                end
            end
            ST_POLY: begin
                if (mul_stat.done) begin
                    if (r_pi == 2'd3) begin
                        if (acc_n < 0) begin
                            n_invalid = 1'b1;
                            n_state   = ST_ASTART;
                        end else begin
                            div_start = 1'b1;
                            div_n     = acc_n + HALF_SCALE;
                            div_d     = POLY_SCALE;
                            n_state   = ST_VDIV;
                        end
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = acc_n;
                        mul_b     = r64;
                        n_pi      = r_pi + 2'd1;
                    end
                end
            end
            // Voltage in uV and its range checks
            ST_VDIV: begin
                if (div_stat.done) begin
                    if (div_q == '0 || div_q >= {41'd0, r_vref} ||
                        r_rs == '0 || r_rn == '0) begin
                        n_invalid = 1'b1;
                        n_state   = ST_ASTART;
                    end else begin
                        n_v       = div_q[22:0];
                        mul_start = 1'b1;
                        mul_a     = rs64;
                        mul_b     = {41'd0, div_q[22:0]};
                        n_state   = ST_RMUL_A;
                    end
                end
            end
            ST_RMUL_A: begin
                if (mul_stat.done) begin
                    n_x     = mul_prod;
                    n_s     = '0;
                    n_sel   = 1'b0;
                    n_state = ST_NORM;
                end
            end
            ST_RMUL_B: begin
                if (mul_stat.done) begin
                    n_x     = mul_prod;
                    n_s     = '0;
                    n_sel   = 1'b1;
                    n_state = ST_NORM;
                end
            end
            // log2: normalize one bit a cycle
            ST_NORM: begin
                if (r_x[63]) begin
                    mul_start = 1'b1;
                    mul_a     = {33'd0, r_x[63:33]};
                    mul_b     = {33'd0, r_x[63:33]};
                    n_k       = 6'd63 - r_s;
                    n_frac    = '0;
                    n_j       = '0;
                    n_state   = ST_SQR;
                end else begin
                    n_x = {r_x[62:0], 1'b0};
                    n_s = r_s + 6'd1;
                end
            end
            // log2: one fraction bit per squaring
            ST_SQR: begin
                if (mul_stat.done) begin
                    n_frac = frac_nx;
                    if (r_j == 5'd29) begin
                        if (!r_sel) begin
                            n_la      = logv;
                            mul_start = 1'b1;
                            mul_a     = rn64;
                            mul_b     = vdiff;
                            n_state   = ST_RMUL_B;
                        end else begin
                            n_dneg    = d_s[63];
                            mul_start = 1'b1;
                            mul_a     = mag;
                            mul_b     = LN2_Q24;
                            n_state   = ST_LN;
                        end
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = {33'd0, m_nx};
                        mul_b     = {33'd0, m_nx};
                        n_j       = r_j + 5'd1;
                    end
                end
            end
            // ln ratio in Q24, then L * T0
            ST_LN: begin
                if (mul_stat.done) begin
                    mul_start = 1'b1;
                    mul_a     = r_dneg ? 64'(-lm) : lm;
                    mul_b     = 64'(t0);
                    n_state   = ST_DEN;
                end
            end
            ST_DEN: begin
                if (mul_stat.done) begin
                    if (den_s <= 0) begin
                        n_invalid = 1'b1;
                        n_state   = ST_ASTART;
                    end else begin
                        n_den     = 64'(den_s);
                        mul_start = 1'b1;
                        mul_a     = b100;
                        mul_b     = 64'(t0);
                        n_state   = ST_NUM;
                    end
                end
            end
            ST_NUM: begin
                if (mul_stat.done) begin
                    div_start = 1'b1;
                    div_n     = (mul_prod << 24) + (r_den >> 1);
                    div_d     = r_den;
                    n_state   = ST_TDIV;
                end
            end
            // Kelvin to Celsius, saturated
            ST_TDIV: begin
                if (div_stat.done) begin
                    if (tc > 64'sd32767) begin
                        n_temp = 16'sh7fff;
                    end else if (tc < -64'sd32768) begin
                        n_temp = 16'sh8000;
                    end else begin
                        n_temp = tc[15:0];
                    end
                    n_state = ST_ASTART;
                end
            end
            ST_ASTART: begin
                div_start = 1'b1;
                div_n     = avg_n;
                div_d     = avg_d;
                n_state   = ST_AWAIT;
            end
            // Old average, then for a valid reading the sum update and new average
            ST_AWAIT: begin
                if (div_stat.done) begin
                    if (r_invalid || r_phase) begin
                        n_res   = clamp_t16(avg26);
                        n_state = ST_OUT;
                    end else begin
                        if (held_c < w_eff) begin
                            n_held = r_held + 1'b1;
                        end
                        if (s26 > SUM_MAX) begin
                            n_sum = SUM_MAX[23:0];
                        end else if (s26 < SUM_MIN) begin
                            n_sum = SUM_MIN[23:0];
                        end else begin
                            n_sum = s26[23:0];
                        end
                        n_phase = 1'b1;
                        n_state = ST_ASTART;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_res;
                    n_out_inv   = r_invalid;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_held      <= '0;
            r_invalid   <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_held      <= n_held;
            r_invalid   <= n_invalid;
            r_phase     <= n_phase;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_pi      <= n_pi;
        r_v       <= n_v;
        r_x       <= n_x;
        r_s       <= n_s;
        r_k       <= n_k;
        r_frac    <= n_frac;
        r_j       <= n_j;
        r_sel     <= n_sel;
        r_dneg    <= n_dneg;
        r_la      <= n_la;
        r_den     <= n_den;
        r_temp    <= n_temp;
        r_res     <= n_res;
        r_out_avg <= n_out_avg;
        r_out_inv <= n_out_inv;
    end

    assign o_in_stall            = (r_state != ST_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_average_temperature = r_out_avg;
    assign o_reading_invalid     = r_out_inv;

    // Count never passes the window limit
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_c <= CW'(MAX_WINDOW))
        else $error("samples held above window limit");

    // The two arithmetic units are never in use together
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    // An accepted beat closes the input until its result is out
    a_in_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // Count stays unchanged while a rejected reading is in work
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_invalid && r_state != ST_IDLE) |=> $stable(r_held))
        else $error("count changed for rejected reading");

endmodule

@@ hdl/tta_serial_mul.sv @@
// Shift-and-add multiplier: one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero. Product is mod 2^64.
// Depends on tta_pkg.
module tta_serial_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tta_pkg::DATA_W-1:0]  i_mcand,
    input  logic [tta_pkg::DATA_W-1:0]  i_mplier,
    output logic [tta_pkg::DATA_W-1:0]  o_prod,
    output tta_pkg::t_unit_status       o_status
);
    import tta_pkg::*;

    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_p;
    logic              r_busy;
    logic              r_done;

    // Iteration: add shifted multiplicand for each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_mcand;
                r_b    <= i_mplier;
                r_p    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_p <= r_p + r_a;
                    end
                    r_a <= {r_a[DATA_W-2:0], 1'b0};
                    r_b <= {1'b0, r_b[DATA_W-1:1]};
                end
            end
        end
    end

    assign o_prod          = r_p;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

@@ hdl/tta_serial_div.sv @@
// Restoring divider: one quotient bit per cycle.
// Unsigned 64 by 64 bits. Depends on tta_pkg.
module tta_serial_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tta_pkg::DATA_W-1:0]  i_dividend,
    input  logic [tta_pkg::DATA_W-1:0]  i_divisor,
    output logic [tta_pkg::DATA_W-1:0]  o_quotient,
    output tta_pkg::t_unit_status       o_status
);
    import tta_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_d;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_q[DATA_W-1]};
        ge    = trial >= {1'b0, r_d};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CNT_W'(DATA_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient      = r_q;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule
